@@ hw/rtl/bmprle_pkg.sv @@
package bmprle_pkg;

  // default palette depth
  localparam int PALETTE_DEPTH_DEF = 256;

  // item command codes
  localparam logic [1:0] CMD_PALETTE = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_START   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // cursor limits and nibble mask
  localparam logic [15:0] COL_MAX     = 16'hFFFF;
  localparam logic [16:0] ROW_MAX     = 17'h1FFFF;
  localparam logic [7:0]  NIBBLE_MASK = 8'h0F;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  stream_byte;
    logic [7:0]  palette_slot;
    logic [23:0] palette_color;
  } item_t;

  typedef struct packed {
    logic [15:0] row;
    logic [15:0] start_col;
    logic [7:0]  run_length;
    logic [23:0] color_first;
    logic [23:0] color_second;
    logic        alternating;
    logic        finished;
  } result_t;

  // result waiting for its palette read
  typedef struct packed {
    logic [15:0] row;
    logic [15:0] start_col;
    logic [7:0]  run_length;
    logic        alternating;
    logic        finished;
    logic        zero_first;
    logic        zero_second;
  } pend_t;

endpackage

@@ hw/rtl/bmprle_ram.sv @@
module bmprle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ hw/rtl/bmp_rle_decoder.sv @@
// BMP RLE8/RLE4 decoder. One request (a compressed byte, a palette write or a
// start of a new image) is taken every clock cycle, and each byte that draws
// pixels or ends the image gives one pixel-run result; the palette read
// stage reads the palette, then the output register is loaded. The only
// thing that slows the input is a stalled output while both the palette
// read stage and the output register are full. The palette sits in a RAM
// with one write port and two registered read ports, so an RLE4 byte fetches
// both nibble colors at once; a palette write is visible to the very next
// byte. Palette entries that were never written read back as garbage. The
// parser state (phase, cursor, literal and pad counts) lives in registers
// and is updated in the cycle a byte is accepted. Configuration (mode, width,
// height) may only be written while the decoder is idle; cfg_ready is always
// high, and writes to an unknown index are dropped.
module bmp_rle_decoder
  import bmprle_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

  // parser phases
  localparam logic [2:0] PH_OPCODE  = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_DX      = 3'd2;
  localparam logic [2:0] PH_DY      = 3'd3;
  localparam logic [2:0] PH_LITERAL = 3'd4;
  localparam logic [2:0] PH_PAD     = 3'd5;

  // configuration registers
  logic        mode_rle4;
  logic [15:0] image_width;
  logic [15:0] image_height;

  // parser state
  logic [2:0]  phase, phase_next;
  logic [15:0] cursor_col, cursor_col_next;
  logic [16:0] cursor_row, cursor_row_next;
  logic [7:0]  held_opcode, held_opcode_next;
  logic [7:0]  literal_left, literal_left_next;
  logic [1:0]  pad_left, pad_left_next;
  logic        done_flag, done_next;

  // pipeline
  logic        pend_valid;
  pend_t       pend, pend_next;
  logic        pend_fire;
  logic        pend_move;
  logic        accept;

  // palette
  logic [23:0] pal_a, pal_b;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic        wr_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_rle4    <= 1'b0;
      image_width  <= 16'd1;
      image_height <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode_rle4    <= cfg_data[0];
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // request moves on when the read stage can drain or is empty
  assign pend_move  = !result_valid || !result_stall;
  assign item_stall = pend_valid && !pend_move;
  assign accept     = item_valid && !item_stall;

  // end condition: past the last row, or last row filled
  function automatic logic end_at(logic [16:0] row, logic [15:0] col,
                                  logic [15:0] w, logic [15:0] h);
    logic past;
    logic last;
    past = row >= {1'b0, h};
    last = ((row + 17'd1) == {1'b0, h}) && (col >= w);
    return past || last;
  endfunction

  // palette addressing: rle4 reads both nibbles, rle8 the whole byte
  logic [7:0] sb;
  logic       byte_oob;
  assign sb        = item.stream_byte;
  assign byte_oob  = {1'b0, sb} >= DEPTH_LIM;
  assign rd_addr_a = mode_rle4 ? AW'(sb[7:4]) : sb[AW-1:0];
  assign rd_addr_b = AW'(sb & NIBBLE_MASK);
  assign wr_en     = accept && (item.command == CMD_PALETTE) &&
                     ({1'b0, item.palette_slot} < DEPTH_LIM);

  bmprle_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (item.palette_slot[AW-1:0]),
    .wr_data  (item.palette_color),
    .rd_en    (accept),
    .rd_addr_a(rd_addr_a),
    .rd_data_a(pal_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_b(pal_b)
  );

  // parser next state
  logic [7:0]  draw_cnt;
  logic [15:0] room;
  logic [7:0]  draw_len;
  logic [16:0] col_sum;
  logic [17:0] row_sum;
  logic [7:0]  lit_cnt;

  always_comb begin
    phase_next        = phase;
    cursor_col_next   = cursor_col;
    cursor_row_next   = cursor_row;
    held_opcode_next  = held_opcode;
    literal_left_next = literal_left;
    pad_left_next     = pad_left;
    done_next         = done_flag;
    pend_fire         = 1'b0;

    // literal step size
    if (mode_rle4) begin
      lit_cnt = (literal_left >= 8'd2) ? 8'd2 : literal_left;
    end else begin
      lit_cnt = (literal_left != 8'd0) ? 8'd1 : 8'd0;
    end
    draw_cnt = (phase == PH_LITERAL) ? lit_cnt : held_opcode;

    // clip the run at the row end
    room = image_width - cursor_col;
    if (cursor_col < image_width) begin
      draw_len = ({8'd0, draw_cnt} < room) ? draw_cnt : room[7:0];
    end else begin
      draw_len = 8'd0;
    end

    col_sum = {1'b0, cursor_col} + 17'(held_opcode);
    row_sum = {1'b0, cursor_row} + 18'(sb);

    // result defaults: a finish marker at the cursor
    pend_next.row         = cursor_row[16] ? 16'hFFFF : cursor_row[15:0];
    pend_next.start_col   = cursor_col;
    pend_next.run_length  = 8'd0;
    pend_next.alternating = 1'b0;
    pend_next.zero_first  = 1'b1;
    pend_next.zero_second = 1'b1;

    if (accept) begin
      case (item.command)
        CMD_START: begin
          phase_next        = PH_OPCODE;
          cursor_col_next   = 16'd0;
          cursor_row_next   = 17'd0;
          held_opcode_next  = 8'd0;
          literal_left_next = 8'd0;
          pad_left_next     = 2'd0;
          done_next         = 1'b0;
        end
        CMD_BYTE: begin
          if (!done_flag) begin
            case (phase)
              PH_OPCODE: begin
                if (end_at(cursor_row, cursor_col, image_width, image_height)) begin
                  done_next = 1'b1;
                  pend_fire = 1'b1;
                end else begin
                  held_opcode_next = sb;
                  phase_next       = PH_SECOND;
                end
              end
              PH_SECOND: begin
                if (held_opcode != 8'd0) begin
                  // encoded run
                  pend_next.run_length  = draw_len;
                  pend_next.alternating = mode_rle4;
                  pend_next.zero_first  = !mode_rle4 && byte_oob;
                  pend_next.zero_second = !mode_rle4 && byte_oob;
                  cursor_col_next = cursor_col + 16'(draw_len);
                  phase_next      = PH_OPCODE;
                  done_next = end_at(cursor_row, cursor_col_next,
                                     image_width, image_height);
                  pend_fire = 1'b1;
                end else if (sb == 8'd0) begin
                  // end of line
                  cursor_row_next = (cursor_row < ROW_MAX) ? cursor_row + 17'd1
                                                           : cursor_row;
                  cursor_col_next = 16'd0;
                  phase_next      = PH_OPCODE;
                  done_next = end_at(cursor_row_next, cursor_col_next,
                                     image_width, image_height);
                  // finish marker sits at the new line start
                  pend_next.row       = cursor_row_next[16] ? 16'hFFFF
                                                            : cursor_row_next[15:0];
                  pend_next.start_col = cursor_col_next;
                  pend_fire = done_next;
                end else if (sb == 8'd1) begin
                  // end of bitmap
                  phase_next = PH_OPCODE;
                  done_next  = 1'b1;
                  pend_fire  = 1'b1;
                end else if (sb == 8'd2) begin
                  phase_next = PH_DX;
                end else begin
                  // absolute run; pad to a 16-bit boundary
                  literal_left_next = sb;
                  pad_left_next = {1'b0, mode_rle4 ? sb[1] ^ sb[0] : sb[0]};
                  phase_next    = PH_LITERAL;
                end
              end
              PH_DX: begin
                held_opcode_next = sb;
                phase_next       = PH_DY;
              end
              PH_DY: begin
                if (cursor_col < image_width) begin
                  cursor_col_next = col_sum[16] ? COL_MAX : col_sum[15:0];
                end
                cursor_row_next = (row_sum > {1'b0, ROW_MAX}) ? ROW_MAX
                                                              : row_sum[16:0];
                phase_next = PH_OPCODE;
                done_next  = end_at(cursor_row_next, cursor_col_next,
                                    image_width, image_height);
                // finish marker sits at the moved cursor
                pend_next.row       = cursor_row_next[16] ? 16'hFFFF
                                                          : cursor_row_next[15:0];
                pend_next.start_col = cursor_col_next;
                pend_fire  = done_next;
              end
              PH_LITERAL: begin
                pend_next.run_length  = draw_len;
                pend_next.alternating = mode_rle4;
                pend_next.zero_first  = !mode_rle4 && byte_oob;
                pend_next.zero_second = !mode_rle4 && byte_oob;
                cursor_col_next   = cursor_col + 16'(draw_len);
                literal_left_next = literal_left - lit_cnt;
                if (literal_left_next == 8'd0) begin
                  if (pad_left != 2'd0) begin
                    phase_next = PH_PAD;
                  end else begin
                    phase_next = PH_OPCODE;
                    done_next  = end_at(cursor_row, cursor_col_next,
                                        image_width, image_height);
                  end
                end
                pend_fire = 1'b1;
              end
              PH_PAD: begin
                pad_left_next = (pad_left != 2'd0) ? pad_left - 2'd1 : pad_left;
                if (pad_left_next == 2'd0) begin
                  phase_next = PH_OPCODE;
                  done_next  = end_at(cursor_row, cursor_col,
                                      image_width, image_height);
                end
                pend_fire = done_next;
              end
              default: begin
                phase_next = PH_OPCODE;
                done_next  = end_at(cursor_row, cursor_col,
                                    image_width, image_height);
                pend_fire  = done_next;
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    pend_next.finished = done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_OPCODE;
      cursor_col   <= 16'd0;
      cursor_row   <= 17'd0;
      held_opcode  <= 8'd0;
      literal_left <= 8'd0;
      pad_left     <= 2'd0;
      done_flag    <= 1'b0;
    end else begin
      phase        <= phase_next;
      cursor_col   <= cursor_col_next;
      cursor_row   <= cursor_row_next;
      held_opcode  <= held_opcode_next;
      literal_left <= literal_left_next;
      pad_left     <= pad_left_next;
      done_flag    <= done_next;
    end
  end

  // read stage: holds the result while the palette data comes back
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= pend_fire;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= pend_next;
    end
  end

  // colors from the palette read, zero where the index is out of range
  logic [23:0] color_a, color_b;
  assign color_a = pend.zero_first ? 24'd0 : pal_a;
  assign color_b = pend.zero_second ? 24'd0 :
                   (pend.alternating ? pal_b : pal_a);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pend_move) begin
      result_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move && pend_valid) begin
      result.row          <= pend.row;
      result.start_col    <= pend.start_col;
      result.run_length   <= pend.run_length;
      result.color_first  <= color_a;
      result.color_second <= color_b;
      result.alternating  <= pend.alternating;
      result.finished     <= pend.finished;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import bmprle_pkg::*;

  // command value the block does not know, must be dropped
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // second byte of an escape (first byte zero)
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  // two stage pipeline, give it some margin before touching config
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_REQUESTS = 135;

  typedef enum logic [2:0] {
    PH_OPCODE, PH_SECOND, PH_DX, PH_DY, PH_LITERAL, PH_PAD
  } parse_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;

  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bmp_rle_decoder dut (.*);

  // requests waiting to be driven, runs waiting to be seen
  item_t request_queue[$];
  result_t expected_runs[$];

  int n_queued = 0;
  int n_accepted = 0;
  int n_fail = 0;
  int n_runs = 0;
  int n_alt_runs = 0;
  int n_end_runs = 0;
  int n_settings = 0;

  // bursts with no idling on either side
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  // decoder mirror: configuration
  bit          m_rle4;
  int unsigned m_width;
  int unsigned m_height;
  logic [23:0] m_pal [256];

  // decoder mirror: parser and cursor
  parse_e      m_phase;
  int unsigned m_col;
  int unsigned m_row;
  logic [7:0]  m_held;
  logic [7:0]  m_lit;
  logic [1:0]  m_pad;
  bit          m_done;

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // decoder mirror
  // ---------------------------------------------------------------------

  function automatic void clear_image();
    m_phase = PH_OPCODE;
    m_col = 0;
    m_row = 0;
    m_held = '0;
    m_lit = '0;
    m_pad = '0;
    m_done = 1'b0;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      REG_MODE:   m_rle4 = val[0];
      REG_WIDTH:  m_width = val;
      REG_HEIGHT: m_height = val;
      default: ;
    endcase
  endfunction

  // cursor left the image or filled its last row
  function automatic bit image_full();
    if (m_row >= m_height) return 1'b1;
    return (m_row + 1 == m_height) && (m_col >= m_width);
  endfunction

  function automatic void close_command();
    m_phase = PH_OPCODE;
    if (image_full()) m_done = 1'b1;
  endfunction

  function automatic result_t run_at_cursor(int unsigned len, logic [23:0] c1,
                                            logic [23:0] c2, bit alt);
    result_t r;
    r.row = (m_row > 65535) ? 16'hFFFF : m_row[15:0];
    r.start_col = m_col[15:0];
    r.run_length = len[7:0];
    r.color_first = c1;
    r.color_second = c2;
    r.alternating = alt;
    r.finished = m_done;
    return r;
  endfunction

  // pixels drawn at the cursor, clipped at the row end
  function automatic result_t paint(int unsigned count, logic [23:0] c1,
                                    logic [23:0] c2, bit alt);
    result_t r;
    int unsigned len;
    len = 0;
    if (m_col < m_width) begin
      len = m_width - m_col;
      if (count < len) len = count;
    end
    r = run_at_cursor(len, c1, c2, alt);
    m_col += len;
    return r;
  endfunction

  function automatic result_t paint_byte(int unsigned count, logic [7:0] b);
    if (m_rle4) return paint(count, m_pal[b[7:4]], m_pal[b & NIBBLE_MASK], 1'b1);
    return paint(count, m_pal[b], m_pal[b], 1'b0);
  endfunction

  // empty run that only reports the end of the image
  function automatic void push_end_run();
    if (m_done) expected_runs.push_back(run_at_cursor(0, '0, '0, 1'b0));
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    result_t r;
    int unsigned cnt;
    if (m_done) return;
    case (m_phase)
      PH_OPCODE: begin
        if (image_full()) begin
          m_done = 1'b1;
          push_end_run();
        end else begin
          m_held = b;
          m_phase = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (m_held != 0) begin
          // encoded run
          r = paint_byte(m_held, b);
          close_command();
          r.finished = m_done;
          expected_runs.push_back(r);
        end else begin
          case (b)
            ESC_EOL: begin
              if (m_row < ROW_MAX) m_row++;
              m_col = 0;
              close_command();
            end
            ESC_EOB: begin
              m_phase = PH_OPCODE;
              m_done = 1'b1;
            end
            ESC_DELTA: m_phase = PH_DX;
            default: begin
              // absolute run, padded to a 16-bit boundary
              m_lit = b;
              m_pad = m_rle4 ? 2'(((int'(b) + 1) >> 1) & 1) : 2'(b & 1);
              m_phase = PH_LITERAL;
            end
          endcase
          push_end_run();
        end
      end
      PH_DX: begin
        m_held = b;
        m_phase = PH_DY;
      end
      PH_DY: begin
        // dx only counts while the column is inside the row
        if (m_col < m_width) begin
          m_col += m_held;
          if (m_col > COL_MAX) m_col = COL_MAX;
        end
        m_row += b;
        if (m_row > ROW_MAX) m_row = ROW_MAX;
        close_command();
        push_end_run();
      end
      PH_LITERAL: begin
        if (m_rle4) cnt = (m_lit >= 2) ? 2 : m_lit;
        else cnt = (m_lit != 0) ? 1 : 0;
        r = paint_byte(cnt, b);
        m_lit = m_lit - 8'(cnt);
        if (m_lit == 0) begin
          if (m_pad != 0) m_phase = PH_PAD;
          else close_command();
        end
        r.finished = m_done;
        expected_runs.push_back(r);
      end
      PH_PAD: begin
        if (m_pad != 0) m_pad--;
        if (m_pad == 0) close_command();
        push_end_run();
      end
      default: begin
        close_command();
        push_end_run();
      end
    endcase
  endfunction

  function automatic void decode_request(item_t it);
    case (it.command)
      CMD_PALETTE: m_pal[it.palette_slot] = it.palette_color;
      CMD_BYTE:    decode_byte(it.stream_byte);
      CMD_START:   clear_image();
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // request driver: one request per handshake, random gap after each
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (item_valid && !item_stall) begin
        decode_request(item);
        n_accepted++;
      end
      // a stalled request holds its payload
      if (!item_valid || !item_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          item <= request_queue.pop_front();
          item_valid <= 1'b1;
          if ($urandom_range(0, 31) == 0) calm_in = !calm_in;
          gap_left = calm_in ? 0 : $urandom_range(0, 4);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // run monitor and checker
  // ---------------------------------------------------------------------

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  function automatic void check_run(result_t got);
    result_t want;
    if (expected_runs.size() == 0) begin
      $error("run with nothing expected: row %0d col %0d len %0d",
             got.row, got.start_col, got.run_length);
      n_fail++;
      return;
    end
    want = expected_runs.pop_front();
    check_field("row", want.row, got.row);
    check_field("start_col", want.start_col, got.start_col);
    check_field("run_length", want.run_length, got.run_length);
    check_field("color_first", want.color_first, got.color_first);
    check_field("color_second", want.color_second, got.color_second);
    check_field("alternating", want.alternating, got.alternating);
    check_field("finished", want.finished, got.finished);
    n_runs++;
    if (want.alternating) n_alt_runs++;
    if (want.finished) n_end_runs++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        check_run(result);
        if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
        stall_left = calm_out ? 0 : $urandom_range(0, 4);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      result_stall <= (stall_left != 0);
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers, unused fields get random values
  // ---------------------------------------------------------------------

  task automatic put_req(logic [1:0] cmd, logic [7:0] b, logic [7:0] slot,
                         logic [23:0] color);
    item_t it;
    it.command = cmd;
    it.stream_byte = b;
    it.palette_slot = slot;
    it.palette_color = color;
    request_queue.push_back(it);
    n_queued++;
  endtask

  task automatic put_byte(logic [7:0] b);
    put_req(CMD_BYTE, b, 8'($urandom), 24'($urandom));
  endtask

  task automatic put_palette(logic [7:0] slot, logic [23:0] color);
    put_req(CMD_PALETTE, 8'($urandom), slot, color);
  endtask

  task automatic put_start();
    put_req(CMD_START, 8'($urandom), 8'($urandom), 24'($urandom));
  endtask

  task automatic put_run(logic [7:0] count, logic [7:0] value);
    put_byte(count);
    put_byte(value);
  endtask

  task automatic put_escape(logic [7:0] code);
    put_byte(8'd0);
    put_byte(code);
  endtask

  task automatic put_delta(logic [7:0] dx, logic [7:0] dy);
    put_escape(ESC_DELTA);
    put_byte(dx);
    put_byte(dy);
  endtask

  // absolute run of n pixels, data bytes plus pad to an even count
  task automatic put_literal(int n);
    int nbytes;
    nbytes = m_rle4 ? (n + 1) / 2 : n;
    put_escape(8'(n));
    repeat (nbytes) put_byte(8'($urandom));
    if (nbytes % 2 != 0) put_byte(8'($urandom));
  endtask

  // one image: mostly well-formed commands, a little noise; cut short
  // once the request count reaches stop_at
  task automatic put_image(int n_cmds, int stop_at);
    put_start();
    for (int k = 0; k < n_cmds && n_queued < stop_at; k++) begin
      int pick;
      int sel;
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 9);
      if (pick < 40) begin
        if (sel == 0) put_run(8'd255, 8'($urandom));
        else if (sel == 1) put_run(8'($urandom_range(1, 255)), 8'($urandom));
        else put_run(8'($urandom_range(1, 12)), 8'($urandom));
      end else if (pick < 50) begin
        put_escape(ESC_EOL);
      end else if (pick < 58) begin
        put_delta(sel == 0 ? 8'd255 : 8'($urandom_range(0, 10)),
                  sel == 1 ? 8'($urandom) : 8'($urandom_range(0, 2)));
      end else if (pick < 85) begin
        put_literal(sel == 0 ? $urandom_range(3, 255) : $urandom_range(3, 12));
      end else if (pick < 88) begin
        put_palette(8'($urandom), 24'($urandom));
      end else if (pick < 91) begin
        // stray byte knocks the parser out of step
        put_byte(8'($urandom));
      end else if (pick < 93) begin
        put_req(CMD_UNUSED, 8'($urandom), 8'($urandom), 24'($urandom));
      end else if (pick < 95) begin
        put_escape(ESC_EOB);
      end else begin
        // restart in the middle of an image
        put_start();
      end
    end
    if ($urandom_range(0, 1) == 0) put_escape(ESC_EOB);
  endtask

  // ---------------------------------------------------------------------
  // idle detection and configuration writes
  // ---------------------------------------------------------------------

  // all requests taken and all runs seen, then let the pipeline drain
  task automatic settle();
    while (n_accepted != n_queued || expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  // valid stays high across the three writes, dropped once at the end
  task automatic set_config(bit rle4, logic [15:0] w, logic [15:0] h);
    write_reg(REG_MODE, {15'd0, rle4});
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------

  initial begin
    int target;
    m_rle4 = 1'b0;
    m_width = 1;
    m_height = 1;
    clear_image();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // rle8, narrow image so clipping and the end show up quickly
    set_config(1'b0, 16'd8, 16'd3);

    // whole palette first, so no pixel ever reads an unwritten entry
    for (int s = 0; s < 256; s++) begin
      if (s == 0) put_palette(8'd0, 24'h000000);
      else if (s == 255) put_palette(8'd255, 24'hFFFFFF);
      else put_palette(8'(s), 24'($urandom));
    end

    // directed rle8: run, run clipped at the row end, run past the width,
    // delta past the width, end of line, odd literal with pad, delta that
    // ends the image, bytes after the end, unknown command, end of bitmap
    put_start();
    put_run(8'd3, 8'h00);
    put_run(8'd255, 8'hFF);
    put_run(8'd2, 8'h10);
    put_delta(8'd5, 8'd1);
    put_escape(ESC_EOL);
    put_literal(3);
    put_delta(8'd255, 8'd0);
    put_byte(8'h05);
    put_req(CMD_UNUSED, 8'h01, 8'h00, 24'h123456);
    put_start();
    put_escape(ESC_EOB);
    settle();

    // directed rle4 at the largest image: alternating runs, odd literal
    // with its dropped low nibble, literals with and without pad
    set_config(1'b1, 16'hFFFF, 16'hFFFF);
    put_start();
    put_run(8'd255, 8'hAB);
    put_literal(3);
    put_literal(5);
    put_literal(4);
    put_delta(8'd255, 8'd255);
    put_escape(ESC_EOL);
    put_run(8'd1, 8'hF0);
    put_escape(ESC_EOB);
    settle();

    // zero width clips everything, the end of line onto the last row ends it
    set_config(1'b0, 16'd0, 16'd2);
    put_start();
    put_run(8'd4, 8'h33);
    put_escape(ESC_EOL);
    put_run(8'd1, 8'h44);
    settle();

    // zero height ends on the very first byte
    set_config(1'b1, 16'd5, 16'd0);
    put_start();
    put_byte(8'h07);
    put_byte(8'h09);
    settle();

    // random images over a range of settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(1'b0, 16'd16, 16'd4);
        1: set_config(1'b1, 16'd16, 16'd4);
        2: set_config(1'b0, 16'd1, 16'd1);
        3: set_config(1'b1, 16'hFFFF, 16'hFFFF);
        4: set_config(1'b1, 16'd1, 16'd3);
        default: set_config(1'($urandom), 16'($urandom_range(1, 40)),
                            16'($urandom_range(1, 8)));
      endcase
      target = n_queued + PHASE_REQUESTS;
      while (n_queued < target) put_image($urandom_range(3, 20), target);
      // sender holds off here until every run has come back
      settle();
    end

    settle();
    $display("%0d requests over %0d settings, %0d runs checked", n_accepted,
             n_settings, n_runs);
    $display("%0d alternating runs, %0d end-of-image runs", n_alt_runs, n_end_runs);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ bmp_rle_decoder.f @@
hw/rtl/bmprle_pkg.sv
hw/rtl/bmprle_ram.sv
hw/rtl/bmp_rle_decoder.sv
tb/sv/tb.sv
